/* hdl/rc4_pkg.sv */
// Shared types and constants for the RC4 stream cipher core.
// No dependencies; used by rc4_engine and rc4_stream_cipher_core.
`timescale 1ns / 1ps

package rc4_pkg;

  localparam int KEY_W     = 64;             // width of one key register
  localparam int KEY_BYTES = 16;
  localparam int REG_IDX_W = 1;              // two key registers

  localparam logic [REG_IDX_W-1:0] REG_KEY_LOW  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_KEY_HIGH = 1'b1;

  localparam logic [7:0] LAST_ENTRY = 8'hff;

  // Result handed from the engine to the output register.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } res_t;

endpackage

/* hdl/rc4_engine.sv */
// RC4 engine: permutation memory, key schedule and keystream sequencer.
// Depends on rc4_pkg (res_t, LAST_ENTRY, KEY_W, KEY_BYTES).
`timescale 1ns / 1ps

module rc4_engine (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [2*rc4_pkg::KEY_W-1:0]    key,
  input  logic                           in_valid,
  input  logic [7:0]                     data_byte,
  input  logic                           last,
  input  logic                           out_free,
  output logic                           in_stall,
  output logic                           res_load,
  output rc4_pkg::res_t                  res
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INIT  = 3'd1;
  localparam logic [2:0] ST_KS_RD = 3'd2;
  localparam logic [2:0] ST_KS_J  = 3'd3;
  localparam logic [2:0] ST_KS_WR = 3'd4;
  localparam logic [2:0] ST_PR_I  = 3'd5;
  localparam logic [2:0] ST_PR_J  = 3'd6;
  localparam logic [2:0] ST_PR_WR = 3'd7;

  logic [2:0] state;
  logic [7:0] n;
  logic [7:0] i;
  logic [7:0] j;
  logic [7:0] si;
  logic [7:0] jx;
  logic [7:0] data_q;
  logic       last_q;
  logic       in_message;
  logic       ks_pend;
  logic       fwd_j;
  logic       pw_en;
  logic [7:0] pw_addr;
  logic [7:0] pw_data;

  // permutation memory, one write and one read port, registered read
  logic [7:0] mem [0:255];
  logic [7:0] mem_q;
  logic       byp;
  logic [7:0] byp_data;

  logic       re;
  logic [7:0] ra;
  logic       mwe;
  logic [7:0] mwa;
  logic [7:0] mwd;
  logic       we;
  logic [7:0] wa;
  logic [7:0] wd;
  logic [7:0] rd;

  logic       can_take;
  logic       accept;
  logic [7:0] kb;
  logic [7:0] jn;
  logic [7:0] j1;
  logic [7:0] t_addr;
  logic [7:0] ks;

  assign rd = byp ? byp_data : mem_q;
  assign kb = key[{n[$clog2(rc4_pkg::KEY_BYTES)-1:0], 3'b000} +: 8];
  assign jn = 8'(j + rd + kb);
  assign j1 = 8'(j + rd);
  assign t_addr = 8'(si + rd);

  assign can_take = (state == ST_IDLE) && (!ks_pend || out_free);
  assign in_stall = !can_take;
  assign accept   = can_take && in_valid;

  always_comb begin
    re  = 1'b0;
    ra  = 8'd0;
    mwe = 1'b0;
    mwa = 8'd0;
    mwd = 8'd0;
    case (state)
      ST_IDLE: begin
        if (accept && in_message) begin
          re = 1'b1;
          ra = 8'(i + 8'd1);
        end
      end
      ST_INIT: begin
        mwe = 1'b1;
        mwa = n;
        mwd = n;
      end
      ST_KS_RD: begin
        re = 1'b1;
        ra = n;
      end
      ST_KS_J: begin
        re = 1'b1;
        ra = jn;
      end
      ST_KS_WR: begin
        mwe = 1'b1;
        mwa = n;
        mwd = rd;
      end
      ST_PR_I: begin
        re = 1'b1;
        ra = 8'(i + 8'd1);
      end
      ST_PR_J: begin
        re = 1'b1;
        ra = j1;
      end
      ST_PR_WR: begin
        // write S[i] and read the keystream entry in the same cycle
        mwe = 1'b1;
        mwa = i;
        mwd = rd;
        re  = 1'b1;
        ra  = t_addr;
      end
      default: begin
        re  = 1'b0;
        mwe = 1'b0;
      end
    endcase
  end

  // deferred second half of each swap goes out in the following cycle
  assign we = mwe | pw_en;
  assign wa = pw_en ? pw_addr : mwa;
  assign wd = pw_en ? pw_data : mwd;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      mem_q    <= mem[ra];
      byp      <= we && (wa == ra);
      byp_data <= wd;
    end
  end

  // keystream byte: S[t] unless t hits the still pending write of S[j]
  assign ks       = fwd_j ? si : rd;
  assign res_load = (state == ST_IDLE) && ks_pend && out_free;
  assign res.data = data_q ^ ks;
  assign res.last = last_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      n          <= 8'd0;
      i          <= 8'd0;
      j          <= 8'd0;
      in_message <= 1'b0;
      ks_pend    <= 1'b0;
      pw_en      <= 1'b0;
    end else begin
      pw_en <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (res_load) begin
            ks_pend <= 1'b0;
          end
          if (accept) begin
            if (in_message) begin
              i          <= 8'(i + 8'd1);
              in_message <= !last;
              state      <= ST_PR_J;
            end else begin
              n     <= 8'd0;
              state <= ST_INIT;
            end
          end
        end
        ST_INIT: begin
          n <= 8'(n + 8'd1);
          j <= 8'd0;
          if (n == rc4_pkg::LAST_ENTRY) begin
            state <= ST_KS_RD;
          end
        end
        ST_KS_RD: begin
          state <= ST_KS_J;
        end
        ST_KS_J: begin
          si    <= rd;
          jx    <= jn;
          j     <= jn;
          state <= ST_KS_WR;
        end
        ST_KS_WR: begin
          pw_en   <= 1'b1;
          pw_addr <= jx;
          pw_data <= si;
          n       <= 8'(n + 8'd1);
          if (n == rc4_pkg::LAST_ENTRY) begin
            i     <= 8'd0;
            j     <= 8'd0;
            state <= ST_PR_I;
          end else begin
            state <= ST_KS_RD;
          end
        end
        ST_PR_I: begin
          i          <= 8'(i + 8'd1);
          in_message <= !last_q;
          state      <= ST_PR_J;
        end
        ST_PR_J: begin
          si    <= rd;
          jx    <= j1;
          j     <= j1;
          state <= ST_PR_WR;
        end
        ST_PR_WR: begin
          pw_en   <= 1'b1;
          pw_addr <= jx;
          pw_data <= si;
          fwd_j   <= (t_addr == jx);
          ks_pend <= 1'b1;
          state   <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_q <= data_byte;
      last_q <= last;
    end
  end

  // deferred write never collides with a sequencer write
  a_no_write_clash: assert property (@(posedge clk) disable iff (rst)
    !(pw_en && mwe))
    else $error("deferred swap write collides with another write");

  // a finished keystream byte only waits in idle
  a_pend_idle: assert property (@(posedge clk) disable iff (rst)
    ks_pend |-> (state == ST_IDLE))
    else $error("keystream byte pending outside idle");

  // swap completion leaves the result pending in idle in the next cycle
  a_wr_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PR_WR) |=> (state == ST_IDLE) && ks_pend && pw_en)
    else $error("swap write not followed by result and deferred write");

  // a request outside a message starts the key schedule
  a_new_msg: assert property (@(posedge clk) disable iff (rst)
    (accept && !in_message) |=> (state == ST_INIT) && (n == 8'd0))
    else $error("new message did not start the key schedule");

endmodule

/* hdl/rc4_stream_cipher_core.sv */
// RC4 stream cipher core, top level: key registers and output register.
// Depends on rc4_pkg and rc4_engine.
`timescale 1ns / 1ps

// Usage
//  - Key: write key_low (index 0) and key_high (index 1) through wr_en /
//    wr_index / wr_data while the core is idle. Key byte 0 sits in bits 7:0
//    of key_low, byte 8 in bits 7:0 of key_high. A new key takes effect at
//    the start of the next message.
//  - Input: a request (data_byte, last) is taken when in_valid is high and
//    in_stall is low. last marks the final byte of a message.
//  - Output: one request (out_byte, out_last) per input byte, in order,
//    moved when out_valid is high and out_stall is low.
//  - Sequence: inside a message each byte runs three accesses (S[i], S[j],
//    S[t]) in turn through the single permutation memory port pair, so a
//    new byte is taken only once the swap of the last one is done.
//  - The first byte of each message first runs the key schedule on the
//    memory: a fill of all 256 entries, then a read, a read and a swap
//    write for each entry, then the first read of S[i].
//  - Reset clears both key registers, the indices and the message flag;
//    the permutation is rebuilt before first use, so it needs no clearing.
//  - When out_stall holds a result, the core finishes the byte in flight
//    and holds its keystream byte; in_stall stays high until the output
//    register frees up.
module rc4_stream_cipher_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [rc4_pkg::REG_IDX_W-1:0]  wr_index,
  input  logic [rc4_pkg::KEY_W-1:0]      wr_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     data_byte,
  input  logic                           last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [7:0]                     out_byte,
  output logic                           out_last
);

  logic [rc4_pkg::KEY_W-1:0] key_low;
  logic [rc4_pkg::KEY_W-1:0] key_high;
  logic                      out_free;
  logic                      res_load;
  rc4_pkg::res_t             res;

  // key registers; index decode from the package
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
    end else if (wr_en) begin
      case (wr_index)
        rc4_pkg::REG_KEY_LOW:  key_low  <= wr_data;
        rc4_pkg::REG_KEY_HIGH: key_high <= wr_data;
        default: begin
          key_low <= key_low;
        end
      endcase
    end
  end

  // output slot is free when empty or being drained this cycle
  assign out_free = !out_valid || !out_stall;

  rc4_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .key       ({key_high, key_low}),
    .in_valid  (in_valid),
    .data_byte (data_byte),
    .last      (last),
    .out_free  (out_free),
    .in_stall  (in_stall),
    .res_load  (res_load),
    .res       (res)
  );

  // output register decouples the receiver from the engine
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_byte <= res.data;
      out_last <= res.last;
    end
  end

endmodule

/* sim/testbench.sv */
// Self-checking testbench for rc4_stream_cipher_core: known-answer vectors, then random messages
// checked against an RC4 keystream predictor kept inside this file.
// Depends on rc4_pkg and rc4_stream_cipher_core.
`timescale 1ns / 1ps

module testbench;

  localparam int RAND_ITEMS     = 2000;
  localparam int WATCHDOG_LIMIT = 20000;  // must stay well above the key schedule run
  localparam int IDLE_PCT       = 13;

  typedef enum logic [1:0] {
    ROW_BYTE,
    ROW_KEY_LOW,
    ROW_KEY_HIGH
  } row_kind_t;

  // value holds the key word for key rows, data in bits 7:0 for byte rows.
  // typed = 1 means want is a published expected output byte, not the predictor's.
  typedef struct packed {
    row_kind_t   kind;
    logic [63:0] value;
    logic        lst;
    logic        typed;
    logic [7:0]  want;
  } stim_row_t;

  localparam int N_ROWS = 23;
  localparam stim_row_t DIR_ROWS [N_ROWS] = '{
    // zero key after reset: keystream de 18 89 41
    '{ROW_BYTE,     64'h00,                  1'b0, 1'b1, 8'hde},
    '{ROW_BYTE,     64'h00,                  1'b0, 1'b1, 8'h18},
    '{ROW_BYTE,     64'h00,                  1'b0, 1'b1, 8'h89},
    '{ROW_BYTE,     64'hff,                  1'b1, 1'b1, 8'hbe},
    // key 01 23 45 67 89 ab cd ef repeated: keystream 74 94 c2 e7
    '{ROW_KEY_LOW,  64'hefcdab8967452301,    1'b0, 1'b0, 8'h00},
    '{ROW_KEY_HIGH, 64'hefcdab8967452301,    1'b0, 1'b0, 8'h00},
    '{ROW_BYTE,     64'h00,                  1'b0, 1'b1, 8'h74},
    '{ROW_BYTE,     64'h00,                  1'b0, 1'b1, 8'h94},
    '{ROW_BYTE,     64'h00,                  1'b0, 1'b1, 8'hc2},
    '{ROW_BYTE,     64'h00,                  1'b1, 1'b1, 8'he7},
    // same key, plaintext 01 23 45 67 89 -> 75 b7 87 80 99
    '{ROW_BYTE,     64'h01,                  1'b0, 1'b1, 8'h75},
    '{ROW_BYTE,     64'h23,                  1'b0, 1'b1, 8'hb7},
    '{ROW_BYTE,     64'h45,                  1'b0, 1'b1, 8'h87},
    // key change while the message is open: stream must carry on untouched
    '{ROW_KEY_LOW,  64'hffffffffffffffff,    1'b0, 1'b0, 8'h00},
    '{ROW_KEY_HIGH, 64'hffffffffffffffff,    1'b0, 1'b0, 8'h00},
    '{ROW_BYTE,     64'h67,                  1'b0, 1'b1, 8'h80},
    '{ROW_BYTE,     64'h89,                  1'b1, 1'b1, 8'h99},
    // all-ones key now active: one-byte message, then a two-byte one
    '{ROW_BYTE,     64'h5a,                  1'b1, 1'b0, 8'h00},
    '{ROW_BYTE,     64'ha5,                  1'b0, 1'b0, 8'h00},
    '{ROW_BYTE,     64'hff,                  1'b1, 1'b0, 8'h00},
    // back to zero key, one-byte message
    '{ROW_KEY_LOW,  64'h0,                   1'b0, 1'b0, 8'h00},
    '{ROW_KEY_HIGH, 64'h0,                   1'b0, 1'b0, 8'h00},
    '{ROW_BYTE,     64'h00,                  1'b1, 1'b1, 8'hde}
  };

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          wr_en     = 1'b0;
  logic [rc4_pkg::REG_IDX_W-1:0] wr_index  = rc4_pkg::REG_KEY_LOW;
  logic [rc4_pkg::KEY_W-1:0]     wr_data   = '0;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  logic [7:0]                    data_byte = 8'h00;
  logic                          last      = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [7:0]                    out_byte;
  logic                          out_last;

  rc4_stream_cipher_core dut (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .last      (last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  always #6 clk = ~clk;

  // Predictor state: its own copy of the key and the permutation.
  logic [63:0] key_lo_q = '0;
  logic [63:0] key_hi_q = '0;
  logic [7:0]  sbox [256];
  logic [7:0]  idx_i    = '0;
  logic [7:0]  idx_j    = '0;
  logic        msg_open = 1'b0;

  rc4_pkg::res_t expected_out [$];
  int          n_fail   = 0;
  logic        idle_on  = 1'b1;
  logic        typed_on = 1'b0;   // current request carries a published answer
  logic [7:0]  typed_byte = '0;

  // One keystream step; a closed message first runs the key schedule.
  function automatic rc4_pkg::res_t cipher_byte(input logic [7:0] d, input logic l);
    rc4_pkg::res_t r;
    logic [127:0]  key;
    logic [7:0]    jj, t, ks_idx;
    if (!msg_open) begin
      key = {key_hi_q, key_lo_q};
      for (int n = 0; n < 256; n++) sbox[n] = n[7:0];
      jj = '0;
      for (int n = 0; n < 256; n++) begin
        jj = jj + sbox[n] + key[(n % 16) * 8 +: 8];
        t = sbox[n];
        sbox[n] = sbox[jj];
        sbox[jj] = t;
      end
      idx_i = '0;
      idx_j = '0;
      msg_open = 1'b1;
    end
    idx_i = idx_i + 8'd1;
    idx_j = idx_j + sbox[idx_i];
    t = sbox[idx_i];
    sbox[idx_i] = sbox[idx_j];
    sbox[idx_j] = t;
    ks_idx = sbox[idx_i] + sbox[idx_j];
    r.data = d ^ sbox[ks_idx];
    r.last = l;
    if (l) msg_open = 1'b0;
    return r;
  endfunction

  // Scoreboard and watchdog, all sampled at the rising edge.
  always @(posedge clk) begin
    rc4_pkg::res_t want;
    int            quiet;
    if (rst) begin
      quiet = 0;
    end else begin
      quiet++;
      if (out_valid && !out_stall) begin
        quiet = 0;
        if (expected_out.size() == 0) begin
          $display("%0t: unexpected result: out_byte %02h out_last %0b",
                   $time, out_byte, out_last);
          n_fail++;
        end else begin
          want = expected_out.pop_front();
          if (out_byte !== want.data) begin
            $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                     $time, want.data, out_byte);
            n_fail++;
          end
          if (out_last !== want.last) begin
            $display("%0t: out_last mismatch: expected %0b, actual %0b",
                     $time, want.last, out_last);
            n_fail++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        quiet = 0;
        want = cipher_byte(data_byte, last);
        if (typed_on) want.data = typed_byte;
        expected_out.push_back(want);
      end
      if (wr_en) quiet = 0;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding",
                 $time, expected_out.size());
        $display("** rc4_stream_cipher_core: FAILED **");
        $finish;
      end
    end
  end

  // Random output backpressure.
  always @(negedge clk) begin
    out_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Drive one request, after an optional random idle gap, and hold it until accepted. Returns at a falling edge.
  task automatic send_byte(input logic [7:0] d, input logic l,
                           input logic chk, input logic [7:0] w);
    if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    typed_on   = chk;
    typed_byte = w;
    in_valid  <= 1'b1;
    data_byte <= d;
    last      <= l;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Sender holds off until every expected result is back.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_out.size() != 0) @(negedge clk);
  endtask

  // Only called with the core idle, so the predictor key can follow at once.
  task automatic write_key(input logic [rc4_pkg::REG_IDX_W-1:0] idx,
                           input logic [63:0] v);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= v;
    if (idx == rc4_pkg::REG_KEY_LOW) key_lo_q = v;
    else                             key_hi_q = v;
    @(negedge clk);
    wr_en <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [63:0] pick_key();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    int sent;
    int msg_no;
    int len;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part
    for (int r = 0; r < N_ROWS; r++) begin
      if (DIR_ROWS[r].kind == ROW_BYTE) begin
        send_byte(DIR_ROWS[r].value[7:0], DIR_ROWS[r].lst,
                  DIR_ROWS[r].typed, DIR_ROWS[r].want);
      end else begin
        drain_results();
        write_key(DIR_ROWS[r].kind == ROW_KEY_LOW ? rc4_pkg::REG_KEY_LOW
                                                  : rc4_pkg::REG_KEY_HIGH,
                  DIR_ROWS[r].value);
      end
    end

    // Random messages: mostly short, every 14th one long enough to wrap i.
    sent   = 0;
    msg_no = 0;
    while (sent < RAND_ITEMS) begin
      idle_on = !(sent >= 600 && sent < 1000);
      if (msg_no == 5 || $urandom_range(0, 5) == 0) begin
        drain_results();
        case ($urandom_range(0, 3))
          0: write_key(rc4_pkg::REG_KEY_LOW, pick_key());
          1: write_key(rc4_pkg::REG_KEY_HIGH, pick_key());
          2: begin
            write_key(rc4_pkg::REG_KEY_LOW, pick_key());
            write_key(rc4_pkg::REG_KEY_HIGH, pick_key());
          end
          default: ;  // pause with the key left alone
        endcase
      end
      len = (msg_no % 14 == 13) ? $urandom_range(257, 400) : $urandom_range(1, 40);
      for (int b = 0; b < len; b++) begin
        // now and then change the key while this message is still open
        if (b == len / 2 && len > 2 && $urandom_range(0, 9) == 0) begin
          drain_results();
          write_key(rc4_pkg::REG_KEY_LOW, pick_key());
        end
        send_byte(8'($urandom_range(0, 255)), b == len - 1, 1'b0, 8'h00);
        sent++;
      end
      msg_no++;
    end
    idle_on = 1'b1;

    drain_results();
    repeat (40) @(negedge clk);
    if (n_fail == 0) begin
      $display("** rc4_stream_cipher_core: PASSED **");
    end else begin
      $display("** rc4_stream_cipher_core: FAILED **");
    end
    $finish;
  end

endmodule
